FILE: rtl/ibtld_pkg.sv
package ibtld_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int TIME_W     = 32;
  localparam int SUM_W      = 32;
  localparam int CNT_W      = 16;
  localparam int SQ_W       = 32;
  localparam int NUM_AXES   = 6;
  localparam int ACC_AXES   = 3;
  localparam int AXIS_W     = 3;
  localparam int IN_W       = TIME_W + NUM_AXES * SAMPLE_W;
  localparam int OUT_W      = NUM_AXES * SAMPLE_W;
  localparam int USER_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int MINCNT_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TARE_END  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = 2'd2;

  localparam logic [SAMPLE_W-1:0]   RST_TARE_END  = 16'd5000;
  localparam logic [SQ_W-1:0]       RST_THRESHOLD = 32'd26214400;
  localparam logic [MINCNT_W-1:0]   RST_MIN_COUNT = 3'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic              load_in;
    logic              corr;
    logic              div_start;
    logic              div_store;
    logic              sq_step;
    logic              finish;
    logic [AXIS_W-1:0] axis;
  } ibtld_cmd_t;

  typedef struct packed {
    logic closing;
    logic div_done;
    logic out_free;
  } ibtld_sts_t;

  function automatic sample_t sat16(input logic signed [SAMPLE_W:0] v);
    sample_t res;
    if (v > 17'sd32767) begin
      res = 16'sh7FFF;
    end else if (v < -17'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/ibtld_div.sv
module ibtld_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [ibtld_pkg::SUM_W-1:0]  dividend,
  input  logic [ibtld_pkg::CNT_W-1:0]         divisor,
  output logic                                busy,
  output logic                                done,
  output ibtld_pkg::sample_t                  quotient
);
  import ibtld_pkg::*;

  localparam int STEPS  = SUM_W;
  localparam int STEP_W = $clog2(STEPS);

  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  den_r;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      quo_r <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], fits};
      rem_r <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  always_comb begin
    if (!neg_r) begin
      quotient = (quo_r > 32'd32767) ? 16'sh7FFF : quo_r[SAMPLE_W-1:0];
    end else begin
      quotient = (quo_r > 32'd32768) ? 16'sh8000 : (~quo_r[SAMPLE_W-1:0] + 1'b1);
    end
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

FILE: rtl/ibtld_dp.sv
module ibtld_dp #(
  parameter int WINDOW_LEN       = 5,
  parameter int MAX_TARE_SAMPLES = 65535
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic [ibtld_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ibtld_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [ibtld_pkg::IN_W-1:0]            in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ibtld_pkg::OUT_W-1:0]           out_tdata,
  output logic [ibtld_pkg::USER_W-1:0]          out_tuser,
  input  ibtld_pkg::ibtld_cmd_t                 cmd,
  output ibtld_pkg::ibtld_sts_t                 sts
);
  import ibtld_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_LEN + 1);

  logic [SAMPLE_W-1:0]   tare_end_r;
  logic [SQ_W-1:0]       thr_r;
  logic [MINCNT_W-1:0]   min_cnt_r;

  logic [TIME_W-1:0]     time_r;
  sample_t               s_r    [NUM_AXES];
  sample_t               o_r    [NUM_AXES];
  sample_t               o_nxt  [NUM_AXES];
  logic signed [SUM_W-1:0] sum_r [NUM_AXES];
  sample_t               bias_r [NUM_AXES];
  logic [CNT_W-1:0]      cnt_r;
  logic                  tare_fin_r;
  logic [SQ_W-1:0]       mag_r;
  logic [WINDOW_LEN-1:0] win_r;
  logic [WINDOW_LEN-1:0] win_nxt;
  logic [WINDOW_LEN:0]   win_ext;
  logic [FILL_W-1:0]     fill_r;
  logic [FILL_W-1:0]     fill_nxt;
  logic [FILL_W-1:0]     pop;
  logic                  launch_r;
  logic                  launch_nxt;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;
  logic [USER_W-1:0]     out_user_r;

  logic                  in_tare;
  logic                  accumulate;
  logic                  gt;
  logic signed [SQ_W-1:0] sq;
  sample_t               sq_sel;
  logic                  div_busy;
  logic                  div_done;
  sample_t               div_q;

  assign in_tare    = time_r < {{(TIME_W - SAMPLE_W){1'b0}}, tare_end_r};
  assign accumulate = !tare_fin_r && in_tare && (cnt_r < CNT_W'(MAX_TARE_SAMPLES));

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (tare_fin_r) begin
        o_nxt[i] = sat16({s_r[i][SAMPLE_W-1], s_r[i]} - {bias_r[i][SAMPLE_W-1], bias_r[i]});
      end else begin
        o_nxt[i] = s_r[i];
      end
    end
  end

  assign sq_sel = o_r[cmd.axis];
  assign sq     = sq_sel * sq_sel;

  assign gt      = mag_r > thr_r;
  assign win_ext = {win_r, gt};
  assign win_nxt = win_ext[WINDOW_LEN-1:0];
  assign fill_nxt = (fill_r < FILL_W'(WINDOW_LEN)) ? fill_r + 1'b1 : fill_r;

  always_comb begin
    pop = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      pop = pop + FILL_W'(win_nxt[i]);
    end
  end

  assign launch_nxt = launch_r ||
                      ((fill_nxt == FILL_W'(WINDOW_LEN)) && (32'(pop) >= 32'(min_cnt_r)));

  ibtld_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r[cmd.axis]),
    .divisor  (cnt_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tare_end_r <= RST_TARE_END;
      thr_r      <= RST_THRESHOLD;
      min_cnt_r  <= RST_MIN_COUNT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TARE_END:  tare_end_r <= cfg_data[SAMPLE_W-1:0];
        CFG_THRESHOLD: thr_r      <= cfg_data[SQ_W-1:0];
        CFG_MIN_COUNT: min_cnt_r  <= cfg_data[MINCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      time_r <= in_tdata[TIME_W-1:0];
      for (int i = 0; i < NUM_AXES; i++) begin
        s_r[i] <= in_tdata[TIME_W + i*SAMPLE_W +: SAMPLE_W];
      end
    end
    if (cmd.corr) begin
      o_r   <= o_nxt;
      mag_r <= '0;
    end else if (cmd.sq_step) begin
      mag_r <= mag_r + SQ_W'(sq);
    end
    if (cmd.finish) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        out_data_r[i*SAMPLE_W +: SAMPLE_W] <= o_r[i];
      end
      out_user_r <= {launch_nxt, tare_fin_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        sum_r[i]  <= '0;
        bias_r[i] <= '0;
      end
      cnt_r       <= '0;
      tare_fin_r  <= 1'b0;
      win_r       <= '0;
      fill_r      <= '0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.corr) begin
        if (accumulate) begin
          for (int i = 0; i < NUM_AXES; i++) begin
            sum_r[i] <= sum_r[i] + SUM_W'(s_r[i]);
          end
          cnt_r <= cnt_r + 1'b1;
        end
        if (sts.closing) begin
          tare_fin_r <= 1'b1;
        end
      end
      if (cmd.div_store) begin
        bias_r[cmd.axis] <= (cnt_r == '0) ? '0 : div_q;
      end
      if (cmd.finish) begin
        win_r       <= win_nxt;
        fill_r      <= fill_nxt;
        launch_r    <= launch_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.closing  = !tare_fin_r && !in_tare;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy) else $error("divider started while busy");
  a_tare_hold: assert property (@(posedge clk) disable iff (!rst_n)
    tare_fin_r |=> tare_fin_r) else $error("tare flag cleared");
  a_launch_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(launch_r) |-> fill_r == FILL_W'(WINDOW_LEN)) else $error("launch before window full");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free) else $error("result overwritten before transfer");

endmodule

FILE: rtl/ibtld_ctrl.sv
module ibtld_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  ibtld_pkg::ibtld_sts_t  sts,
  output ibtld_pkg::ibtld_cmd_t  cmd
);
  import ibtld_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CORR     = 3'd1;
  localparam logic [2:0] S_DIV_GO   = 3'd2;
  localparam logic [2:0] S_DIV_WAIT = 3'd3;
  localparam logic [2:0] S_SQ       = 3'd4;
  localparam logic [2:0] S_FIN      = 3'd5;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [AXIS_W-1:0] axis_r;
  logic [AXIS_W-1:0] axis_nxt;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    cmd           = '0;
    cmd.axis      = axis_r;
    in_tready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_CORR;
        end
      end
      S_CORR: begin
        cmd.corr = 1'b1;
        axis_nxt = '0;
        state_nxt = sts.closing ? S_DIV_GO : S_SQ;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          if (axis_r == AXIS_W'(NUM_AXES - 1)) begin
            axis_nxt  = '0;
            state_nxt = S_SQ;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        if (axis_r == AXIS_W'(ACC_AXES - 1)) begin
          state_nxt = S_FIN;
        end else begin
          axis_nxt = axis_r + 1'b1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

FILE: rtl/imu_bias_tare_launch_detect.sv
// A sample passes load, correction, three steps on the shared squaring multiplier
// and the output write, which waits while the output register is still full; the
// block takes no new sample until that write, and out_tvalid rises after it.
// The sample that closes the tare also runs six 32-step divisions, one after
// another on a single restoring divider, between correction and squaring.
// Reset is synchronous and active low; control state clears and the config registers take their reset values.
module imu_bias_tare_launch_detect #(
  parameter int WINDOW_LEN       = 5,
  parameter int MAX_TARE_SAMPLES = 65535
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ibtld_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ibtld_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // time_ms, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
  input  logic [ibtld_pkg::IN_W-1:0]        in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_accel_x, out_accel_y, out_accel_z, out_rate_x, out_rate_y, out_rate_z
  output logic [ibtld_pkg::OUT_W-1:0]       out_tdata,
  // tare_done, launch_detected
  output logic [ibtld_pkg::USER_W-1:0]      out_tuser
);
  import ibtld_pkg::*;

  ibtld_cmd_t cmd;
  ibtld_sts_t sts;

  assign cfg_ready = 1'b1;

  ibtld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ibtld_dp #(
    .WINDOW_LEN       (WINDOW_LEN),
    .MAX_TARE_SAMPLES (MAX_TARE_SAMPLES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
